/* rtl/shortest_path_all_orders_search_assert.svh */
// Assertion macros used by the top file, which checks its own logic.
// Each macro names the assertion, the clock and the active-low reset.
`ifndef SHORTEST_PATH_ALL_ORDERS_SEARCH_ASSERT_SVH
`define SHORTEST_PATH_ALL_ORDERS_SEARCH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPAOS_ASSERT_SAME(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("spaos assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SPAOS_ASSERT_NEXT(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("spaos assertion failed");

`endif

/* rtl/spaos_pkg.sv */
package spaos_pkg;

	// Default number of cities.
	localparam int CITIES_DEF = 5;

	// Field widths.
	localparam int EDGE_W = 16;
	localparam int LEN_W  = 18;

	// Path sums before saturation, one bit wider than a path length.
	localparam int SUM_W = 19;

	// Saturated length, also the starting value of the running minimum.
	localparam logic [LEN_W-1:0] LEN_MAX = '1;

	typedef logic [EDGE_W-1:0] edge_t;
	typedef logic [LEN_W-1:0]  len_t;

	// Tells the loader that the search of one matrix bank has finished.
	typedef struct packed {
		logic valid;
		logic bank;
	} release_t;

endpackage

/* rtl/spaos_ram.sv */
module spaos_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one read port with registered read data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/spaos_job_fifo.sv */
module spaos_job_fifo (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic push_bank,
	input  logic pop,
	output logic pop_bank,
	output logic full,
	output logic empty
);

	logic       slot_q [0:1];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = count_q == 2'd2;
	assign empty    = count_q == 2'd0;
	assign pop_bank = slot_q[rd_ptr_q];

	// Pointers and fill level of the two-entry job queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Each job carries only the bank that holds its matrix.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_bank;
		end
	end

endmodule

/* rtl/spaos_front.sv */
module spaos_front #(
	parameter int CITIES = spaos_pkg::CITIES_DEF,
	localparam int AW = $clog2(2 * CITIES * CITIES)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                edge_valid,
	output logic                edge_stall,
	input  spaos_pkg::edge_t    edge_length,
	input  logic                fifo_full,
	input  spaos_pkg::release_t rel,
	output logic                job_push,
	output logic                job_bank,
	output logic                we,
	output logic [AW-1:0]       waddr,
	output spaos_pkg::edge_t    wdata
);

	import spaos_pkg::*;

	localparam int ENTRIES = CITIES * CITIES;
	localparam int CNT_W = $clog2(ENTRIES);
	localparam logic [CNT_W-1:0] LAST_ENTRY = CNT_W'(ENTRIES - 1);
	localparam logic [AW-1:0] BANK_BASE = AW'(ENTRIES);

	logic [CNT_W-1:0] count_q;
	logic             bank_q;
	logic [1:0]       busy_q;
	logic [1:0]       busy_d;
	logic             accept;
	logic             last;

	// A bank that is still being searched cannot take new entries.
	assign edge_stall = busy_q[bank_q] | fifo_full;
	assign accept     = edge_valid & ~edge_stall;
	assign last       = count_q == LAST_ENTRY;

	// Each accepted beat goes straight into the current bank.
	assign we    = accept;
	assign waddr = (bank_q ? BANK_BASE : '0) + AW'(count_q);
	assign wdata = edge_length;

	// The last entry of a matrix hands the bank over to the search.
	assign job_push = accept & last;
	assign job_bank = bank_q;

	always_comb begin
		busy_d = busy_q;
		if (rel.valid) begin
			busy_d[rel.bank] = 1'b0;
		end
		if (job_push) begin
			busy_d[bank_q] = 1'b1;
		end
	end

	// Entry counter, fill bank and bank ownership.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			bank_q  <= 1'b0;
			busy_q  <= 2'b00;
		end else begin
			busy_q <= busy_d;
			if (accept) begin
				if (last) begin
					count_q <= '0;
					bank_q  <= ~bank_q;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

endmodule

/* rtl/spaos_back.sv */
module spaos_back #(
	parameter int CITIES = spaos_pkg::CITIES_DEF,
	localparam int AW = $clog2(2 * CITIES * CITIES)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_empty,
	input  logic                 job_bank,
	output logic                 job_pop,
	output logic                 re,
	output logic [AW-1:0]        raddr,
	input  spaos_pkg::edge_t     rdata,
	output spaos_pkg::release_t  rel,
	output logic                 result_valid,
	input  logic                 result_stall,
	output spaos_pkg::len_t      shortest_length
);

	import spaos_pkg::*;

	localparam int CW = $clog2(CITIES);
	localparam int ENTRIES = CITIES * CITIES;
	localparam logic [AW-1:0] BANK_BASE = AW'(ENTRIES);
	localparam logic [AW-1:0] STRIDE = AW'(CITIES);
	localparam logic [CW-1:0] LAST_EDGE = CW'(CITIES - 2);

	typedef logic [CW-1:0] city_t;
	typedef enum logic [1:0] {IDLE, RUN, FIN} state_t;

	state_t           state_q;
	city_t            digit_q [1:CITIES-1];
	city_t            digit_d [1:CITIES-1];
	city_t            raw [0:CITIES-1];
	city_t            city [0:CITIES-1];
	city_t            edge_q;
	logic             bank_q;
	logic             digits_max;
	logic             issue;
	logic             last_edge;
	logic             rd_s1;
	logic             first_s1;
	logic             last_edge_s1;
	logic             last_order_s1;
	logic [SUM_W-1:0] acc_q;
	logic [SUM_W-1:0] sum;
	len_t             sat;
	len_t             best_q;
	len_t             best_d;
	logic             finish;
	logic             result_valid_q;
	len_t             result_q;

	// Lehmer decode of the factorial-base digits into city numbers.
	always_comb begin
		raw[0]  = '0;
		city[0] = '0;
		for (int k = 1; k < CITIES; k++) begin
			raw[k]  = digit_q[k];
			city[k] = digit_q[k];
		end
		for (int k = CITIES - 1; k > 0; k--) begin
			for (int j = k - 1; j >= 0; j--) begin
				if (raw[j] <= city[k]) begin
					city[k] = city[k] + city_t'(1);
				end
			end
		end
	end

	// Mixed-radix increment; digit k counts up to CITIES-1-k.
	always_comb begin
		logic carry;
		carry      = 1'b1;
		digits_max = 1'b1;
		for (int k = CITIES - 1; k > 0; k--) begin
			digit_d[k] = digit_q[k];
			if (digit_q[k] != CW'(CITIES - 1 - k)) begin
				digits_max = 1'b0;
			end
			if (carry) begin
				if (digit_q[k] == CW'(CITIES - 1 - k)) begin
					digit_d[k] = '0;
				end else begin
					digit_d[k] = digit_q[k] + city_t'(1);
					carry      = 1'b0;
				end
			end
		end
	end

	// One edge of the current order is read each cycle.
	assign issue     = state_q == RUN;
	assign last_edge = edge_q == LAST_EDGE;
	assign re        = issue;
	assign raddr     = (bank_q ? BANK_BASE : '0)
		+ AW'(city[edge_q]) * STRIDE
		+ AW'(city[edge_q + city_t'(1)]);

	// A new job starts only once the previous result has left.
	assign job_pop = (state_q == IDLE) & ~job_empty & ~result_valid_q;

	// Accumulate the edge that returns from memory and keep the minimum.
	assign sum    = (first_s1 ? '0 : acc_q) + SUM_W'(rdata);
	assign sat    = (sum > SUM_W'(LEN_MAX)) ? LEN_MAX : sum[LEN_W-1:0];
	assign best_d = (sat < best_q) ? sat : best_q;
	assign finish = rd_s1 & last_edge_s1 & last_order_s1;

	assign rel.valid = finish;
	assign rel.bank  = bank_q;

	assign result_valid    = result_valid_q;
	assign shortest_length = result_q;

	// Sequencer, read stage and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= IDLE;
			edge_q         <= '0;
			bank_q         <= 1'b0;
			rd_s1          <= 1'b0;
			first_s1       <= 1'b0;
			last_edge_s1   <= 1'b0;
			last_order_s1  <= 1'b0;
			acc_q          <= '0;
			best_q         <= LEN_MAX;
			result_valid_q <= 1'b0;
			result_q       <= '0;
			for (int k = 1; k < CITIES; k++) begin
				digit_q[k] <= '0;
			end
		end else begin
			rd_s1         <= issue;
			first_s1      <= edge_q == '0;
			last_edge_s1  <= last_edge;
			last_order_s1 <= digits_max;
			if (rd_s1) begin
				acc_q <= sum;
			end
			if (rd_s1 & last_edge_s1) begin
				best_q <= best_d;
			end

			unique case (state_q)
				IDLE: begin
					if (job_pop) begin
						bank_q  <= job_bank;
						edge_q  <= '0;
						best_q  <= LEN_MAX;
						state_q <= RUN;
						for (int k = 1; k < CITIES; k++) begin
							digit_q[k] <= '0;
						end
					end
				end
				RUN: begin
					if (last_edge) begin
						edge_q <= '0;
						if (digits_max) begin
							state_q <= FIN;
						end else begin
							for (int k = 1; k < CITIES; k++) begin
								digit_q[k] <= digit_d[k];
							end
						end
					end else begin
						edge_q <= edge_q + city_t'(1);
					end
				end
				FIN: begin
					state_q <= IDLE;
				end
				default: begin
					state_q <= IDLE;
				end
			endcase

			// The result beat waits here until the receiver takes it.
			if (finish) begin
				result_valid_q <= 1'b1;
				result_q       <= best_d;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/shortest_path_all_orders_search.sv */
// Brute-force shortest open path. Feed the CITIES*CITIES distance matrix one entry per beat,
// row-major (row is the from-city). After the last entry the block tries every order of the
// cities that starts at city 0 and returns the least sum of edges along an order as one beat,
// saturated at 2^18-1. The matrix memory has two banks, so the next matrix can be loaded
// while the previous one is searched. The search reads one edge per cycle from the single
// read port of that memory. A search starts only after the previous result beat has been
// taken.
`include "shortest_path_all_orders_search_assert.svh"

module shortest_path_all_orders_search #(
	parameter int CITIES = spaos_pkg::CITIES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             edge_valid,
	output logic             edge_stall,
	input  spaos_pkg::edge_t edge_length,
	output logic             result_valid,
	input  logic             result_stall,
	output spaos_pkg::len_t  shortest_length
);

	import spaos_pkg::*;

	localparam int DEPTH = 2 * CITIES * CITIES;
	localparam int AW = $clog2(DEPTH);

	logic          we;
	logic [AW-1:0] waddr;
	edge_t         wdata;
	logic          re;
	logic [AW-1:0] raddr;
	edge_t         rdata;
	logic          job_push;
	logic          job_bank;
	logic          job_pop;
	logic          pop_bank;
	logic          fifo_full;
	logic          fifo_empty;
	release_t      rel;

	// Loader: stores entries and hands over full matrices.
	spaos_front #(
		.CITIES(CITIES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.edge_valid (edge_valid),
		.edge_stall (edge_stall),
		.edge_length(edge_length),
		.fifo_full  (fifo_full),
		.rel        (rel),
		.job_push   (job_push),
		.job_bank   (job_bank),
		.we         (we),
		.waddr      (waddr),
		.wdata      (wdata)
	);

	// Queue of matrices waiting for the search.
	spaos_job_fifo u_job_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_bank(job_bank),
		.pop      (job_pop),
		.pop_bank (pop_bank),
		.full     (fifo_full),
		.empty    (fifo_empty)
	);

	// Two banks of distance entries.
	spaos_ram #(
		.WIDTH(EDGE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Search over all visiting orders.
	spaos_back #(
		.CITIES(CITIES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.job_empty      (fifo_empty),
		.job_bank       (pop_bank),
		.job_pop        (job_pop),
		.re             (re),
		.raddr          (raddr),
		.rdata          (rdata),
		.rel            (rel),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.shortest_length(shortest_length)
	);

	// The loader never hands over a matrix when the queue has no room.
	`SPAOS_ASSERT_SAME(a_push_room, clk, arst_n, job_push, !fifo_full)
	// The search never takes a job from an empty queue.
	`SPAOS_ASSERT_SAME(a_pop_avail, clk, arst_n, job_pop, !fifo_empty)
	// A finished search shows its result beat in the next cycle.
	`SPAOS_ASSERT_NEXT(a_release_result, clk, arst_n, rel.valid, result_valid)
	// A result beat appears only right after a search has finished.
	`SPAOS_ASSERT_SAME(a_result_origin, clk, arst_n, $rose(result_valid), $past(rel.valid))

endmodule
